// ===== rtl/two_level_free_frame_stack_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the free frame stack
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_FREE_FRAME_STACK_DEFINES_SVH
`define TWO_LEVEL_FREE_FRAME_STACK_DEFINES_SVH

// same-cycle implication, off during reset
`define TLFFS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tlffs port check failed");

// next-cycle implication, off during reset
`define TLFFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tlffs port check failed");

// next-cycle implication, active through reset
`define TLFFS_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("tlffs reset check failed");

`endif

// ===== rtl/tlffs_pkg.sv =====
// ----------------------------------------------------------------------------
// tlffs_pkg
// Types, opcodes and saturating counter helpers for the free frame stack.
// ----------------------------------------------------------------------------
package tlffs_pkg;

    localparam int FRAME_BITS = 12;
    localparam int COUNT_W    = FRAME_BITS + 1;
    localparam int NFRAMES    = 1 << FRAME_BITS;
    localparam int SLOTS_DEF  = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // opcodes
    localparam logic [1:0] OP_SEED  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_OOM = 1'b1;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [FRAME_BITS-1:0] frame_number;
    } t_in_beat;

    typedef struct packed {
        logic [FRAME_BITS-1:0] allocated_frame;
        logic                  status;
        logic [COUNT_W-1:0]    local_free_count;
        logic [COUNT_W-1:0]    global_free_count;
    } t_out_beat;

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_sub(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

// ===== rtl/two_level_free_frame_stack.sv =====
// A result beat reaches the output register after the header read and the entry read.
// One item at a time: header read, entry read, then write back to the block store;
// input stall stays high from accept until the result is registered.
// A full output register that is stalled holds the write-back step.
// Reset (synchronous, active low) clears pool and cache pointers and counters; block store
// contents are left as they are and get no clearing pass.
// ----------------------------------------------------------------------------
// two_level_free_frame_stack
// Free physical frame allocator: a global chain of full blocks behind a
// local cache of two blocks, kept in block storage memories.
// ----------------------------------------------------------------------------
module two_level_free_frame_stack #(
    parameter int SLOTS = tlffs_pkg::SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tlffs_pkg::t_in_beat  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tlffs_pkg::t_out_beat o_out
);

    localparam int FB  = tlffs_pkg::FRAME_BITS;
    localparam int FW  = $clog2(SLOTS + 1);
    localparam int EAW = $clog2(tlffs_pkg::NFRAMES * SLOTS);

    logic                 res_valid;
    logic                 res_ready;
    tlffs_pkg::t_out_beat res;

    logic           fill_rd_en,  fill_wr_en;
    logic [FB-1:0]  fill_rd_addr, fill_wr_addr;
    logic [FW-1:0]  fill_rd_data, fill_wr_data;
    logic           link_rd_en,  link_wr_en;
    logic [FB-1:0]  link_rd_addr, link_wr_addr, link_rd_data, link_wr_data;
    logic           entry_rd_en, entry_wr_en;
    logic [EAW-1:0] entry_rd_addr, entry_wr_addr;
    logic [FB-1:0]  entry_rd_data, entry_wr_data;

    logic                 r_out_valid;
    tlffs_pkg::t_out_beat r_out;

    tlffs_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in            (i_in),
        .o_res_valid     (res_valid),
        .o_res           (res),
        .i_res_ready     (res_ready),
        .o_fill_rd_en    (fill_rd_en),
        .o_fill_rd_addr  (fill_rd_addr),
        .i_fill_rd_data  (fill_rd_data),
        .o_fill_wr_en    (fill_wr_en),
        .o_fill_wr_addr  (fill_wr_addr),
        .o_fill_wr_data  (fill_wr_data),
        .o_link_rd_en    (link_rd_en),
        .o_link_rd_addr  (link_rd_addr),
        .i_link_rd_data  (link_rd_data),
        .o_link_wr_en    (link_wr_en),
        .o_link_wr_addr  (link_wr_addr),
        .o_link_wr_data  (link_wr_data),
        .o_entry_rd_en   (entry_rd_en),
        .o_entry_rd_addr (entry_rd_addr),
        .i_entry_rd_data (entry_rd_data),
        .o_entry_wr_en   (entry_wr_en),
        .o_entry_wr_addr (entry_wr_addr),
        .o_entry_wr_data (entry_wr_data)
    );

    tlffs_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .i_clk           (i_clk),
        .i_fill_rd_en    (fill_rd_en),
        .i_fill_rd_addr  (fill_rd_addr),
        .o_fill_rd_data  (fill_rd_data),
        .i_fill_wr_en    (fill_wr_en),
        .i_fill_wr_addr  (fill_wr_addr),
        .i_fill_wr_data  (fill_wr_data),
        .i_link_rd_en    (link_rd_en),
        .i_link_rd_addr  (link_rd_addr),
        .o_link_rd_data  (link_rd_data),
        .i_link_wr_en    (link_wr_en),
        .i_link_wr_addr  (link_wr_addr),
        .i_link_wr_data  (link_wr_data),
        .i_entry_rd_en   (entry_rd_en),
        .i_entry_rd_addr (entry_rd_addr),
        .o_entry_rd_data (entry_rd_data),
        .i_entry_wr_en   (entry_wr_en),
        .i_entry_wr_addr (entry_wr_addr),
        .i_entry_wr_data (entry_wr_data)
    );

    // output register takes a beat when empty or draining
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result payload
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/tlffs_store.sv =====
// ----------------------------------------------------------------------------
// tlffs_store
// Block storage: fill counts, chain links and slot entries, one read and
// one write port each, registered read data.
// ----------------------------------------------------------------------------
module tlffs_store #(
    parameter int SLOTS = tlffs_pkg::SLOTS_DEF
) (
    input  logic                                i_clk,
    // fill counts
    input  logic                                i_fill_rd_en,
    input  logic [tlffs_pkg::FRAME_BITS-1:0]    i_fill_rd_addr,
    output logic [$clog2(SLOTS+1)-1:0]          o_fill_rd_data,
    input  logic                                i_fill_wr_en,
    input  logic [tlffs_pkg::FRAME_BITS-1:0]    i_fill_wr_addr,
    input  logic [$clog2(SLOTS+1)-1:0]          i_fill_wr_data,
    // chain links
    input  logic                                i_link_rd_en,
    input  logic [tlffs_pkg::FRAME_BITS-1:0]    i_link_rd_addr,
    output logic [tlffs_pkg::FRAME_BITS-1:0]    o_link_rd_data,
    input  logic                                i_link_wr_en,
    input  logic [tlffs_pkg::FRAME_BITS-1:0]    i_link_wr_addr,
    input  logic [tlffs_pkg::FRAME_BITS-1:0]    i_link_wr_data,
    // slot entries
    input  logic                                i_entry_rd_en,
    input  logic [$clog2(tlffs_pkg::NFRAMES*SLOTS)-1:0] i_entry_rd_addr,
    output logic [tlffs_pkg::FRAME_BITS-1:0]    o_entry_rd_data,
    input  logic                                i_entry_wr_en,
    input  logic [$clog2(tlffs_pkg::NFRAMES*SLOTS)-1:0] i_entry_wr_addr,
    input  logic [tlffs_pkg::FRAME_BITS-1:0]    i_entry_wr_data
);

    localparam int FW      = $clog2(SLOTS + 1);
    localparam int ENTRIES = tlffs_pkg::NFRAMES * SLOTS;

    logic [FW-1:0]                    r_fill_mem  [tlffs_pkg::NFRAMES];
    logic [tlffs_pkg::FRAME_BITS-1:0] r_link_mem  [tlffs_pkg::NFRAMES];
    logic [tlffs_pkg::FRAME_BITS-1:0] r_entry_mem [ENTRIES];

    logic [FW-1:0]                    r_fill_rd;
    logic [tlffs_pkg::FRAME_BITS-1:0] r_link_rd;
    logic [tlffs_pkg::FRAME_BITS-1:0] r_entry_rd;

    // fill count memory
    always_ff @(posedge i_clk) begin
        if (i_fill_wr_en) begin
            r_fill_mem[i_fill_wr_addr] <= i_fill_wr_data;
        end
        if (i_fill_rd_en) begin
            r_fill_rd <= r_fill_mem[i_fill_rd_addr];
        end
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (i_link_wr_en) begin
            r_link_mem[i_link_wr_addr] <= i_link_wr_data;
        end
        if (i_link_rd_en) begin
            r_link_rd <= r_link_mem[i_link_rd_addr];
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (i_entry_wr_en) begin
            r_entry_mem[i_entry_wr_addr] <= i_entry_wr_data;
        end
        if (i_entry_rd_en) begin
            r_entry_rd <= r_entry_mem[i_entry_rd_addr];
        end
    end

    assign o_fill_rd_data  = r_fill_rd;
    assign o_link_rd_data  = r_link_rd;
    assign o_entry_rd_data = r_entry_rd;

endmodule

// ===== rtl/tlffs_seq.sv =====
// ----------------------------------------------------------------------------
// tlffs_seq
// Three-step sequencer: read header, read entry, then update the cache and
// pool registers and write the block store back.
// ----------------------------------------------------------------------------
module tlffs_seq #(
    parameter int SLOTS = tlffs_pkg::SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item side
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tlffs_pkg::t_in_beat                 i_in,
    // result side
    output logic                                o_res_valid,
    output tlffs_pkg::t_out_beat                o_res,
    input  logic                                i_res_ready,
    // block store
    output logic                                o_fill_rd_en,
    output logic [tlffs_pkg::FRAME_BITS-1:0]    o_fill_rd_addr,
    input  logic [$clog2(SLOTS+1)-1:0]          i_fill_rd_data,
    output logic                                o_fill_wr_en,
    output logic [tlffs_pkg::FRAME_BITS-1:0]    o_fill_wr_addr,
    output logic [$clog2(SLOTS+1)-1:0]          o_fill_wr_data,
    output logic                                o_link_rd_en,
    output logic [tlffs_pkg::FRAME_BITS-1:0]    o_link_rd_addr,
    input  logic [tlffs_pkg::FRAME_BITS-1:0]    i_link_rd_data,
    output logic                                o_link_wr_en,
    output logic [tlffs_pkg::FRAME_BITS-1:0]    o_link_wr_addr,
    output logic [tlffs_pkg::FRAME_BITS-1:0]    o_link_wr_data,
    output logic                                o_entry_rd_en,
    output logic [$clog2(tlffs_pkg::NFRAMES*SLOTS)-1:0] o_entry_rd_addr,
    input  logic [tlffs_pkg::FRAME_BITS-1:0]    i_entry_rd_data,
    output logic                                o_entry_wr_en,
    output logic [$clog2(tlffs_pkg::NFRAMES*SLOTS)-1:0] o_entry_wr_addr,
    output logic [tlffs_pkg::FRAME_BITS-1:0]    o_entry_wr_data
);

    localparam int FB  = tlffs_pkg::FRAME_BITS;
    localparam int CW  = tlffs_pkg::COUNT_W;
    localparam int FW  = $clog2(SLOTS + 1);
    localparam int EAW = $clog2(tlffs_pkg::NFRAMES * SLOTS);

    localparam logic [FW-1:0]  FILL_FULL = FW'(SLOTS);
    localparam logic [FW-1:0]  FILL_ONE  = FW'(1);
    localparam logic [EAW-1:0] SLOTS_EA  = EAW'(SLOTS);
    localparam logic [CW-1:0]  SLOTS_CNT = CW'(SLOTS);
    localparam logic [CW-1:0]  CNT_ONE   = CW'(1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    // sequencer
    logic [1:0]    r_state, n_state;
    // latched item and read results
    logic [1:0]    r_op;
    logic [FB-1:0] r_frame;
    logic [FB-1:0] r_addr;
    logic [FW-1:0] r_fill;
    logic [FB-1:0] r_link;
    logic [EAW-1:0] r_base;
    // pool and cache registers
    logic [FB-1:0] r_gtop,   n_gtop;
    logic          r_seeded, n_seeded;
    logic [CW-1:0] r_gfree,  n_gfree;
    logic          r_ready,  n_ready;
    logic [FB-1:0] r_first,  n_first;
    logic [FB-1:0] r_second, n_second;
    logic          r_tis,    n_tis;
    logic [CW-1:0] r_lfree,  n_lfree;

    logic           accept;
    logic           commit;
    logic [FB-1:0]  top_blk;
    logic [FB-1:0]  addr_sel;
    logic [FW-1:0]  fill_clamp;
    logic [FW-1:0]  pop_idx;
    logic [EAW-1:0] base_c;
    logic           pool_empty;
    logic [CW-1:0]  take_free;
    logic [CW-1:0]  lf_tmp;
    logic [FB-1:0]  got;
    logic           status;
    logic           fill_we, link_we, entry_we;
    logic [FB-1:0]  fill_wa, link_wa, link_wd;
    logic [FW-1:0]  fill_wd;

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign commit     = (r_state == S_EXEC) && i_res_ready;
    assign o_in_stall = (r_state != S_IDLE);

    // pick the block whose header the item needs
    assign top_blk  = r_tis ? r_second : r_first;
    assign addr_sel = ((i_in.opcode == tlffs_pkg::OP_SEED) || !r_ready) ? r_gtop : top_blk;

    // header reads at accept
    assign o_fill_rd_en   = accept;
    assign o_fill_rd_addr = addr_sel;
    assign o_link_rd_en   = accept;
    assign o_link_rd_addr = r_gtop;

    // entry read once the fill count is back
    assign fill_clamp      = (i_fill_rd_data > FILL_FULL) ? FILL_FULL : i_fill_rd_data;
    assign pop_idx         = (fill_clamp == '0) ? '0 : (fill_clamp - FILL_ONE);
    assign base_c          = EAW'(r_addr) * SLOTS_EA;
    assign o_entry_rd_en   = (r_state == S_READ);
    assign o_entry_rd_addr = base_c + EAW'(pop_idx);

    // step decision
    always_comb begin
        pool_empty = (r_gfree == '0) || !r_seeded;
        take_free  = tlffs_pkg::sat_sub(r_gfree, SLOTS_CNT);
        lf_tmp     = r_lfree;
        n_gtop     = r_gtop;
        n_seeded   = r_seeded;
        n_gfree    = r_gfree;
        n_ready    = r_ready;
        n_first    = r_first;
        n_second   = r_second;
        n_tis      = r_tis;
        n_lfree    = r_lfree;
        got        = '0;
        status     = tlffs_pkg::ST_OK;
        fill_we    = 1'b0;
        fill_wa    = r_addr;
        fill_wd    = '0;
        link_we    = 1'b0;
        link_wa    = r_frame;
        link_wd    = '0;
        entry_we   = 1'b0;
        unique case (r_op)
            tlffs_pkg::OP_SEED: begin
                if (!r_seeded) begin
                    link_we  = 1'b1;
                    fill_we  = 1'b1;
                    fill_wa  = r_frame;
                    n_gtop   = r_frame;
                    n_seeded = 1'b1;
                end else if (r_fill >= FILL_FULL) begin
                    link_we = 1'b1;
                    link_wd = r_gtop;
                    fill_we = 1'b1;
                    fill_wa = r_frame;
                    n_gtop  = r_frame;
                end else begin
                    entry_we = 1'b1;
                    fill_we  = 1'b1;
                    fill_wd  = r_fill + FILL_ONE;
                end
                n_gfree = tlffs_pkg::sat_add(r_gfree, CNT_ONE);
            end
            tlffs_pkg::OP_ALLOC: begin
                if (!r_ready) begin
                    if (pool_empty) begin
                        status = tlffs_pkg::ST_OOM;
                    end else begin
                        n_gtop  = r_link;
                        n_gfree = take_free;
                        if (take_free == '0) begin
                            n_seeded = 1'b0;
                        end
                        n_lfree = SLOTS_CNT - CNT_ONE;
                        if (r_fill == '0) begin
                            got = r_addr;
                        end else begin
                            n_first = r_addr;
                            n_tis   = 1'b0;
                            n_ready = 1'b1;
                            got     = i_entry_rd_data;
                            fill_we = 1'b1;
                            fill_wd = r_fill - FILL_ONE;
                        end
                    end
                end else if (r_fill == '0) begin
                    if (r_tis) begin
                        n_tis   = 1'b0;
                        n_lfree = tlffs_pkg::sat_sub(r_lfree, CNT_ONE);
                        got     = r_addr;
                    end else if (pool_empty) begin
                        status = tlffs_pkg::ST_OOM;
                    end else begin
                        n_first = r_gtop;
                        n_gtop  = r_link;
                        n_gfree = take_free;
                        if (take_free == '0) begin
                            n_seeded = 1'b0;
                        end
                        n_lfree = tlffs_pkg::sat_add(
                            tlffs_pkg::sat_sub(r_lfree, CNT_ONE), SLOTS_CNT);
                        got     = r_addr;
                    end
                end else begin
                    n_lfree = tlffs_pkg::sat_sub(r_lfree, CNT_ONE);
                    got     = i_entry_rd_data;
                    fill_we = 1'b1;
                    fill_wd = r_fill - FILL_ONE;
                end
            end
            tlffs_pkg::OP_FREE: begin
                if (!r_ready) begin
                    if (pool_empty) begin
                        status = tlffs_pkg::ST_OOM;
                    end else begin
                        n_first = r_gtop;
                        n_gtop  = r_link;
                        n_gfree = take_free;
                        if (take_free == '0) begin
                            n_seeded = 1'b0;
                        end
                        fill_we  = 1'b1;
                        fill_wa  = r_frame;
                        n_second = r_frame;
                        n_tis    = 1'b1;
                        n_ready  = 1'b1;
                        n_lfree  = tlffs_pkg::sat_add(SLOTS_CNT, CNT_ONE);
                    end
                end else begin
                    if (r_fill >= FILL_FULL) begin
                        if (r_tis) begin
                            // spill the full second block to the pool
                            link_we  = 1'b1;
                            link_wa  = r_second;
                            link_wd  = r_seeded ? r_gtop : '0;
                            n_gtop   = r_second;
                            n_seeded = 1'b1;
                            n_gfree  = tlffs_pkg::sat_add(r_gfree, SLOTS_CNT);
                            lf_tmp   = tlffs_pkg::sat_sub(r_lfree, SLOTS_CNT);
                        end
                        fill_we  = 1'b1;
                        fill_wa  = r_frame;
                        n_second = r_frame;
                        n_tis    = 1'b1;
                    end else begin
                        entry_we = 1'b1;
                        fill_we  = 1'b1;
                        fill_wd  = r_fill + FILL_ONE;
                    end
                    n_lfree = tlffs_pkg::sat_add(lf_tmp, CNT_ONE);
                end
            end
            default: begin
                // no operation
            end
        endcase
    end

    // write back only on commit
    assign o_fill_wr_en    = commit && fill_we;
    assign o_fill_wr_addr  = fill_wa;
    assign o_fill_wr_data  = fill_wd;
    assign o_link_wr_en    = commit && link_we;
    assign o_link_wr_addr  = link_wa;
    assign o_link_wr_data  = link_wd;
    assign o_entry_wr_en   = commit && entry_we;
    assign o_entry_wr_addr = r_base + EAW'(r_fill);
    assign o_entry_wr_data = r_frame;

    // result beat
    assign o_res_valid                 = commit;
    assign o_res.allocated_frame       = got;
    assign o_res.status                = status;
    assign o_res.local_free_count      = n_lfree;
    assign o_res.global_free_count     = n_gfree;

    // advance the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and pool registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gtop   <= '0;
            r_seeded <= 1'b0;
            r_gfree  <= '0;
            r_ready  <= 1'b0;
            r_first  <= '0;
            r_second <= '0;
            r_tis    <= 1'b0;
            r_lfree  <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_gtop   <= n_gtop;
                r_seeded <= n_seeded;
                r_gfree  <= n_gfree;
                r_ready  <= n_ready;
                r_first  <= n_first;
                r_second <= n_second;
                r_tis    <= n_tis;
                r_lfree  <= n_lfree;
            end
        end
    end

    // hold the item and its header reads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_in.opcode;
            r_frame <= i_in.frame_number;
            r_addr  <= addr_sel;
        end
        if (r_state == S_READ) begin
            r_fill <= fill_clamp;
            r_link <= i_link_rd_data;
            r_base <= base_c;
        end
    end

endmodule

// ===== rtl/tlffs_checker.sv =====
// ----------------------------------------------------------------------------
// tlffs_checker
// Port-level checks for the free frame stack, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_level_free_frame_stack_defines.svh"

module tlffs_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input tlffs_pkg::t_in_beat  i_in,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input tlffs_pkg::t_out_beat o_out
);

    // a stalled result beat holds
    `TLFFS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

    // one item at a time: input stalls right after an accept
    `TLFFS_ASSERT_NEXT(a_one_at_a_time, i_in_valid && !o_in_stall, o_in_stall)

    // an out-of-memory answer hands out no frame
    `TLFFS_ASSERT_NOW(a_oom_no_frame, o_out_valid && (o_out.status == tlffs_pkg::ST_OOM), o_out.allocated_frame == '0)

    // no result beat right after reset
    `TLFFS_ASSERT_RST(a_reset_empty, !i_rst_n, !o_out_valid)

endmodule

bind two_level_free_frame_stack tlffs_checker u_tlffs_checker (.*);
